>>> sv/ri2d_pkg.sv
package ri2d_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STG_W = $clog2(CORDIC_STAGES);

    // Vectoring datapath width, angle width and rotation datapath width.
    localparam int V_W = 52;
    localparam int Z_W = 34;
    localparam int R_W = 34;

    localparam logic signed [Z_W-1:0] ANG_PI      = Z_W'(64'sd1686629713);
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = Z_W'(64'sd843314857);
    localparam logic signed [Z_W-1:0] ANG_TWO_PI  = Z_W'(64'sd3373259426);
    localparam logic signed [R_W-1:0] CORDIC_K    = R_W'(64'sd652032874);

    localparam logic [31:0] ATAN_LO [0:9] = '{
        32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
        32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575
    };

    // Arctangent of 2^-i in Q4.29 radians.
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] r;
        if (i < 10)
            r = signed'(Z_W'(ATAN_LO[i]));
        else
            r = signed'(Z_W'(64'd1 << (29 - i)));
        return r;
    endfunction

endpackage

>>> sv/ri2d_vec_cell.sv
module ri2d_vec_cell
    import ri2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [STG_W-1:0]      stage,
    input  logic signed [V_W-1:0] x_in,
    input  logic signed [V_W-1:0] y_in,
    input  logic signed [Z_W-1:0] z_in,
    output logic signed [V_W-1:0] x_reg,
    output logic signed [V_W-1:0] y_reg,
    output logic signed [Z_W-1:0] z_reg
);

    logic signed [V_W-1:0] x_next, y_next;
    logic signed [Z_W-1:0] z_next;
    logic signed [Z_W-1:0] step;

    always_comb
    begin
        step = atan_step(int'(stage));
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> stage);
            y_next = y_in - (x_in >>> stage);
            z_next = z_in + step;
        end
        else
        begin
            x_next = x_in - (y_in >>> stage);
            y_next = y_in + (x_in >>> stage);
            z_next = z_in - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> sv/ri2d_rot_cell.sv
module ri2d_rot_cell
    import ri2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [STG_W-1:0]      stage,
    input  logic signed [R_W-1:0] x_in,
    input  logic signed [R_W-1:0] y_in,
    input  logic signed [Z_W-1:0] a_in,
    output logic signed [R_W-1:0] x_reg,
    output logic signed [R_W-1:0] y_reg,
    output logic signed [Z_W-1:0] a_reg
);

    logic signed [R_W-1:0] x_next, y_next;
    logic signed [Z_W-1:0] a_next;
    logic signed [Z_W-1:0] step;

    always_comb
    begin
        step = atan_step(int'(stage));
        if (a_in >= 0)
        begin
            x_next = x_in - (y_in >>> stage);
            y_next = y_in + (x_in >>> stage);
            a_next = a_in - step;
        end
        else
        begin
            x_next = x_in + (y_in >>> stage);
            y_next = y_in - (x_in >>> stage);
            a_next = a_in + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            a_reg <= a_next;
        end
    end

endmodule

>>> sv/rotation_interpolator_2d.sv
// Stages from an accepted input beat to its output beat: product stage, two vectoring
// cell rows side by side, fraction multiply, angle sum, rotation cell row and the output
// register. Throughput: one beat per cycle while the skid entry is empty; a two-entry
// output register and skid hold results while the sink stalls, and s_tready drops while
// the skid entry is held. Reset (rst_n, asynchronous, active low) empties the pipeline.
module rotation_interpolator_2d
    import ri2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cos_from[15:0], sin_from[31:16], cos_to[47:32], sin_to[63:48], fraction[81:64]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cos_out[15:0], sin_out[31:16], delta_ang[47:32], degenerate[48]
    output logic [55:0] m_tdata
);

    localparam int N = CORDIC_STAGES;

    logic en;
    logic skid_valid_reg, out_valid_reg;
    logic [48:0] out_reg, skid_reg;

    assign en = !skid_valid_reg;
    assign s_tready = en;

    // Input stage: relative vector products and fraction clamp.
    logic signed [15:0] cf, sf, ct, st;
    logic signed [17:0] fr;
    logic [16:0] f_clamp;

    assign cf = signed'(s_tdata[15:0]);
    assign sf = signed'(s_tdata[31:16]);
    assign ct = signed'(s_tdata[47:32]);
    assign st = signed'(s_tdata[63:48]);
    assign fr = signed'(s_tdata[81:64]);

    always_comb
    begin
        if (fr < 0)
            f_clamp = '0;
        else if (fr > 18'sd65536)
            f_clamp = 17'd65536;
        else
            f_clamp = fr[16:0];
    end

    logic signed [32:0] rx_reg, ry_reg;
    logic signed [15:0] cf_reg, sf_reg;
    logic                  vv_reg [0:N];
    logic [16:0]           vf_reg [0:N];
    logic                  vd_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vv_reg[0] <= 1'b0;
        else if (en)
            vv_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg    <= 33'(32'(cf) * 32'(ct)) + 33'(32'(sf) * 32'(st));
            ry_reg    <= 33'(32'(cf) * 32'(st)) - 33'(32'(sf) * 32'(ct));
            cf_reg    <= cf;
            sf_reg    <= sf;
            vf_reg[0] <= f_clamp;
            vd_reg[0] <= (cf == 0 && sf == 0) || (ct == 0 && st == 0);
        end
    end

    // Quadrant fold ahead of both vectoring rows.
    logic signed [V_W-1:0] rvx, rvy, svx, svy;
    logic signed [V_W-1:0] rx0, ry0, sx0, sy0;
    logic signed [Z_W-1:0] rz0, sz0;

    assign rvx = V_W'(rx_reg) <<< 16;
    assign rvy = V_W'(ry_reg) <<< 16;
    assign svx = V_W'(cf_reg) <<< 24;
    assign svy = V_W'(sf_reg) <<< 24;

    always_comb
    begin
        rx0 = rvx; ry0 = rvy; rz0 = '0;
        if (rvx < 0)
        begin
            if (rvy >= 0)
            begin
                rx0 = rvy; ry0 = -rvx; rz0 = ANG_HALF_PI;
            end
            else
            begin
                rx0 = -rvy; ry0 = rvx; rz0 = -ANG_HALF_PI;
            end
        end
        sx0 = svx; sy0 = svy; sz0 = '0;
        if (svx < 0)
        begin
            if (svy >= 0)
            begin
                sx0 = svy; sy0 = -svx; sz0 = ANG_HALF_PI;
            end
            else
            begin
                sx0 = -svy; sy0 = svx; sz0 = -ANG_HALF_PI;
            end
        end
    end

    logic signed [V_W-1:0] rvx_c [0:N];
    logic signed [V_W-1:0] rvy_c [0:N];
    logic signed [Z_W-1:0] rvz_c [0:N];
    logic signed [V_W-1:0] svx_c [0:N];
    logic signed [V_W-1:0] svy_c [0:N];
    logic signed [Z_W-1:0] svz_c [0:N];

    assign rvx_c[0] = rx0;
    assign rvy_c[0] = ry0;
    assign rvz_c[0] = rz0;
    assign svx_c[0] = sx0;
    assign svy_c[0] = sy0;
    assign svz_c[0] = sz0;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        ri2d_vec_cell u_rel (
            .clk   (clk),
            .en    (en),
            .stage (STG_W'(i)),
            .x_in  (rvx_c[i]),
            .y_in  (rvy_c[i]),
            .z_in  (rvz_c[i]),
            .x_reg (rvx_c[i+1]),
            .y_reg (rvy_c[i+1]),
            .z_reg (rvz_c[i+1])
        );
        ri2d_vec_cell u_start (
            .clk   (clk),
            .en    (en),
            .stage (STG_W'(i)),
            .x_in  (svx_c[i]),
            .y_in  (svy_c[i]),
            .z_in  (svz_c[i]),
            .x_reg (svx_c[i+1]),
            .y_reg (svy_c[i+1]),
            .z_reg (svz_c[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i+1] <= 1'b0;
            else if (en)
                vv_reg[i+1] <= vv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vf_reg[i+1] <= vf_reg[i];
                vd_reg[i+1] <= vd_reg[i];
            end
        end
    end

    // Fraction multiply.
    logic               m_valid_reg, m_deg_reg;
    logic signed [50:0] prod_reg;
    logic signed [Z_W-1:0] m_start_reg, m_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= vv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 51'(rvz_c[N]) * 51'(signed'({1'b0, vf_reg[N]}));
            m_start_reg <= svz_c[N];
            m_diff_reg  <= rvz_c[N];
            m_deg_reg   <= vd_reg[N];
        end
    end

    // Angle sum, wrap into [-pi, pi] and quadrant pre-rotation.
    logic signed [Z_W-1:0] ang_sum, ang_wrap, ang0;
    logic signed [R_W-1:0] x0, y0;

    always_comb
    begin
        ang_sum = m_start_reg + Z_W'(prod_reg >>> 16);
        if (ang_sum > ANG_PI)
            ang_wrap = ang_sum - ANG_TWO_PI;
        else if (ang_sum < -ANG_PI)
            ang_wrap = ang_sum + ANG_TWO_PI;
        else
            ang_wrap = ang_sum;
        x0 = CORDIC_K; y0 = '0; ang0 = ang_wrap;
        if (ang_wrap > ANG_HALF_PI)
        begin
            x0 = '0; y0 = CORDIC_K; ang0 = ang_wrap - ANG_HALF_PI;
        end
        else if (ang_wrap < -ANG_HALF_PI)
        begin
            x0 = '0; y0 = -CORDIC_K; ang0 = ang_wrap + ANG_HALF_PI;
        end
    end

    logic signed [R_W-1:0] rx_c [0:N];
    logic signed [R_W-1:0] ry_c [0:N];
    logic signed [Z_W-1:0] ra_c [0:N];
    logic signed [R_W-1:0] rot_x_reg, rot_y_reg;
    logic signed [Z_W-1:0] rot_a_reg;
    logic                  rv_reg [0:N];
    logic signed [Z_W-1:0] rd_reg [0:N];
    logic                  rg_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_x_reg <= x0;
            rot_y_reg <= y0;
            rot_a_reg <= ang0;
            rd_reg[0] <= m_diff_reg;
            rg_reg[0] <= m_deg_reg;
        end
    end

    assign rx_c[0] = rot_x_reg;
    assign ry_c[0] = rot_y_reg;
    assign ra_c[0] = rot_a_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        ri2d_rot_cell u_cell (
            .clk   (clk),
            .en    (en),
            .stage (STG_W'(i)),
            .x_in  (rx_c[i]),
            .y_in  (ry_c[i]),
            .a_in  (ra_c[i]),
            .x_reg (rx_c[i+1]),
            .y_reg (ry_c[i+1]),
            .a_reg (ra_c[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else if (en)
                rv_reg[i+1] <= rv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg[i+1] <= rd_reg[i];
                rg_reg[i+1] <= rg_reg[i];
            end
        end
    end

    // Rounding and saturation of the final beat.
    logic signed [R_W-1:0] cx, cy;
    logic signed [Z_W-1:0] cd;
    logic signed [15:0] co, so, ad;
    logic [48:0] res;

    always_comb
    begin
        cx = (rx_c[N] + R_W'(16384)) >>> 15;
        cy = (ry_c[N] + R_W'(16384)) >>> 15;
        cd = (rd_reg[N] + Z_W'(32768)) >>> 16;
        if (cx > 32767)
            co = 16'sd32767;
        else if (cx < -32768)
            co = -16'sd32768;
        else
            co = cx[15:0];
        if (cy > 32767)
            so = 16'sd32767;
        else if (cy < -32768)
            so = -16'sd32768;
        else
            so = cy[15:0];
        if (cd > 25736)
            ad = 16'sd25736;
        else if (cd < -25736)
            ad = -16'sd25736;
        else
            ad = cd[15:0];
        if (rg_reg[N])
            res = {1'b1, 16'd0, 16'd0, 16'd32767};
        else
            res = {1'b0, ad, so, co};
    end

    logic push, pop;
    assign push = en && rv_reg[N];
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    // A held skid entry always sits behind a valid output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output beat");

    // A stalled output beat with a full skid keeps the output occupied next cycle.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && out_valid_reg))
        else $error("skid entry lost under stall");

    a_degenerate_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[48]) |-> (m_tdata[47:0] == {16'd0, 16'd0, 16'd32767}))
        else $error("degenerate beat carries wrong values");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd25736
                      && $signed(m_tdata[47:32]) >= -16'sd25736))
        else $error("delta angle out of range");

endmodule

>>> sim/tb_rotation_interpolator_2d.sv
`timescale 1ns / 100ps

module tb_rotation_interpolator_2d;
    import ri2d_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STAGES + 4;
    localparam int N_RANDOM = 970;
    localparam longint PI_Q29 = 64'sd1686629713;
    localparam longint HALF_PI_Q29 = 64'sd843314857;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct packed {
        logic [5:0]         pad;
        logic signed [17:0] fraction;
        logic signed [15:0] sin_to;
        logic signed [15:0] cos_to;
        logic signed [15:0] sin_from;
        logic signed [15:0] cos_from;
    } dir_pair_t;

    typedef struct packed {
        logic [6:0]         pad;
        logic               degenerate;
        logic signed [15:0] delta_ang;
        logic signed [15:0] sin_out;
        logic signed [15:0] cos_out;
    } blend_t;

    typedef struct {
        logic signed [15:0] cf, sf, ct, st;
        logic signed [17:0] fr;
        logic               known;
        blend_t             res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    blend_t expected_blends[$];
    int     error_count;
    bit     quiet_sink;     // sink never stalls while set
    bit     sink_hold;      // long sink hold-off requested

    rotation_interpolator_2d dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_entry(int i);
        longint tbl[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10)
            return tbl[i];
        return longint'(1) << (29 - i);
    endfunction

    function automatic longint vector_angle(longint xi, longint yi);
        longint x, y, z, xs, ys, t;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = HALF_PI_Q29;
            end
            else
            begin
                t = x; x = -y; y = t; z = -HALF_PI_Q29;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan_entry(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic blend_t blend_directions(dir_pair_t d);
        longint cf, sf, ct, st, f, rx, ry, diff, ang, x, y, xs, ys;
        blend_t r;
        cf = d.cos_from;
        sf = d.sin_from;
        ct = d.cos_to;
        st = d.sin_to;
        f = clip(longint'(d.fraction), 0, 65536);
        r = '0;
        if ((cf == 0 && sf == 0) || (ct == 0 && st == 0))
        begin
            r.cos_out = 16'sd32767;
            r.degenerate = 1'b1;
            return r;
        end
        rx = cf * ct + sf * st;
        ry = cf * st - sf * ct;
        diff = vector_angle(rx * 65536, ry * 65536);
        ang = vector_angle(cf * 16777216, sf * 16777216) + floor_shift(diff * f, 16);
        if (ang > PI_Q29)
            ang -= 2 * PI_Q29;
        else if (ang < -PI_Q29)
            ang += 2 * PI_Q29;
        x = GAIN_Q30;
        y = 0;
        if (ang > HALF_PI_Q29)
        begin
            x = 0; y = GAIN_Q30; ang -= HALF_PI_Q29;
        end
        else if (ang < -HALF_PI_Q29)
        begin
            x = 0; y = -GAIN_Q30; ang += HALF_PI_Q29;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (ang >= 0)
            begin
                x -= ys; y += xs; ang -= arctan_entry(i);
            end
            else
            begin
                x += ys; y -= xs; ang += arctan_entry(i);
            end
        end
        r.cos_out = 16'(clip(floor_shift(x + 16384, 15), -32768, 32767));
        r.sin_out = 16'(clip(floor_shift(y + 16384, 15), -32768, 32767));
        r.delta_ang = 16'(clip(floor_shift(diff + 32768, 16), -25736, 25736));
        return r;
    endfunction

    // Offers one beat, with random gaps when gaps is set; returns once it is accepted.
    task automatic send_beat(dir_pair_t d, bit gaps);
        while (gaps && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_blends.push_back(blend_directions(d));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_blends.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_component(int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [17:0] rand_fraction();
        case ($urandom_range(9))
            0: return 18'($urandom);
            1: return 18'sd65536;
            2: return 18'sd0;
            default: return 18'($urandom_range(65536));
        endcase
    endfunction

    // Mostly directions of random length from an angle, plus raw vectors and corners.
    function automatic dir_pair_t rand_pair();
        dir_pair_t d;
        real a, m;
        d = '0;
        if ($urandom_range(3) != 0)
        begin
            a = ($urandom_range(100000) / 100000.0 - 0.5) * 6.2831853;
            m = 1000.0 + $urandom_range(31000);
            d.cos_from = 16'($rtoi(m * $cos(a)));
            d.sin_from = 16'($rtoi(m * $sin(a)));
            a = ($urandom_range(100000) / 100000.0 - 0.5) * 6.2831853;
            m = 1000.0 + $urandom_range(31000);
            d.cos_to = 16'($rtoi(m * $cos(a)));
            d.sin_to = 16'($rtoi(m * $sin(a)));
        end
        else
        begin
            d.cos_from = rand_component($urandom_range(12));
            d.sin_from = rand_component($urandom_range(12));
            d.cos_to = rand_component($urandom_range(12));
            d.sin_to = rand_component($urandom_range(12));
        end
        d.fraction = rand_fraction();
        return d;
    endfunction

    stim_row_t directed[] = '{
        '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 18'sd65536, 1'b1,
          '{7'd0, 1'b1, 16'sd0, 16'sd0, 16'sd32767}},
        '{16'sd100, 16'sd0, 16'sd0, 16'sd0, 18'sd0, 1'b1,
          '{7'd0, 1'b1, 16'sd0, 16'sd0, 16'sd32767}},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -18'sd131072, 1'b1,
          '{7'd0, 1'b1, 16'sd0, 16'sd0, 16'sd32767}},
        '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 18'sd0, 1'b0, '0},
        '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 18'sd32768, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 18'sd65536, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 18'sd131071, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, -18'sd131072, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, -18'sd1, 1'b0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 18'sd65537, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 18'sd65536, 1'b0, '0},
        '{-16'sd32768, 16'sd1, -16'sd32768, -16'sd1, 18'sd65536, 1'b0, '0},
        '{-16'sd32768, -16'sd1, -16'sd32768, 16'sd1, 18'sd40000, 1'b0, '0},
        '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 18'sd65536, 1'b0, '0},
        '{16'sd1, 16'sd0, 16'sd0, 16'sd1, 18'sd32768, 1'b0, '0},
        '{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 18'sd65535, 1'b0, '0},
        '{-16'sd1, -16'sd1, 16'sd1, -16'sd1, 18'sd1, 1'b0, '0},
        '{16'sd23170, -16'sd23170, -16'sd23170, -16'sd23170, 18'sd49152, 1'b0, '0},
        '{-16'sd30000, 16'sd12000, -16'sd30000, -16'sd12000, 18'sd65536, 1'b0, '0}
    };

    // Sink side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                m_tready <= 1'b0;
                for (int i = 0; i < 4 * LATENCY; i++)
                    @(negedge clk);
                sink_hold = 1'b0;
            end
            m_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        blend_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_blends.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_blends.pop_front();
                if (got.cos_out !== want.cos_out)
                begin
                    $display("%0t: cos_out expected %0d actual %0d",
                             $time, want.cos_out, got.cos_out);
                    error_count++;
                end
                if (got.sin_out !== want.sin_out)
                begin
                    $display("%0t: sin_out expected %0d actual %0d",
                             $time, want.sin_out, got.sin_out);
                    error_count++;
                end
                if (got.delta_ang !== want.delta_ang)
                begin
                    $display("%0t: delta_ang expected %0d actual %0d",
                             $time, want.delta_ang, got.delta_ang);
                    error_count++;
                end
                if (got.degenerate !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.degenerate, got.degenerate);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_rotation_interpolator_2d NOT OK");
        $finish;
    end

    initial
    begin
        dir_pair_t d;
        blend_t typed_in;
        error_count = 0;
        quiet_sink = 1'b0;
        sink_hold = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[k])
        begin
            d = '0;
            d.cos_from = directed[k].cf;
            d.sin_from = directed[k].sf;
            d.cos_to = directed[k].ct;
            d.sin_to = directed[k].st;
            d.fraction = directed[k].fr;
            typed_in = blend_directions(d);
            if (directed[k].known && typed_in !== directed[k].res)
            begin
                $display("%0t: row %0d expected %h predicted %h",
                         $time, k, directed[k].res, typed_in);
                error_count++;
            end
            send_beat(d, 1'b1);
        end
        wait_drained();

        // Fill the pipeline against a stalled sink.
        sink_hold = 1'b1;
        for (int i = 0; i < 3 * LATENCY; i++)
            send_beat(rand_pair(), 1'b0);
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            quiet_sink = (i >= 300 && i < 450);
            if (i == 700)
                wait_drained();
            send_beat(rand_pair(), !(i >= 300 && i < 450));
        end
        s_tvalid <= 1'b0;
        quiet_sink = 1'b0;
        while (expected_blends.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (error_count == 0)
            $display("tb_rotation_interpolator_2d OK");
        else
            $display("tb_rotation_interpolator_2d NOT OK");
        $finish;
    end

endmodule
